>>> rtl/pdlf_pkg.sv
// ----------------------------------------------------------------------------
// PD line follower package
// Shared register map, configuration record and controller/datapath links.
// ----------------------------------------------------------------------------
package pdlf_pkg;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam int CENTER_BITS = 13;
   localparam int SCALE_BITS  = 13;
   localparam int GAIN_BITS   = 12;
   localparam int SPEED_BITS  = 10;
   localparam int LIMIT_BITS  = 9;

   localparam logic [2:0] REG_CENTER = 3'd0;
   localparam logic [2:0] REG_SCALE  = 3'd1;
   localparam logic [2:0] REG_KP     = 3'd2;
   localparam logic [2:0] REG_KD     = 3'd3;
   localparam logic [2:0] REG_BASE   = 3'd4;
   localparam logic [2:0] REG_LIMIT  = 3'd5;

   localparam logic [CENTER_BITS-1:0] CENTER_RESET = 13'd2500;
   localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = 13'd2500;
   localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 9'd400;

   typedef struct packed {
      logic [CENTER_BITS-1:0] center;
      logic [SCALE_BITS-1:0]  scale;
      logic [GAIN_BITS-1:0]   kp;
      logic [GAIN_BITS-1:0]   kd;
      logic [SPEED_BITS-1:0]  base;
      logic [LIMIT_BITS-1:0]  limit;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic diff;
      logic mul_p;
      logic mul_d;
      logic setup;
      logic div_step;
      logic fix;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } sts_type;

endpackage

>>> rtl/pdlf_csr.sv
// ----------------------------------------------------------------------------
// PD line follower register file
// Holds the six control registers behind a simple peripheral bus port.
// ----------------------------------------------------------------------------
module pdlf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pdlf_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [pdlf_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [pdlf_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output pdlf_pkg::cfg_type                   cfg
);
   import pdlf_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_CENTER: cfg_in.center = csr_pwdata[CENTER_BITS-1:0];
            REG_SCALE:  cfg_in.scale  = csr_pwdata[SCALE_BITS-1:0];
            REG_KP:     cfg_in.kp     = csr_pwdata[GAIN_BITS-1:0];
            REG_KD:     cfg_in.kd     = csr_pwdata[GAIN_BITS-1:0];
            REG_BASE:   cfg_in.base   = csr_pwdata[SPEED_BITS-1:0];
            REG_LIMIT:  cfg_in.limit  = csr_pwdata[LIMIT_BITS-1:0];
            default:    cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center <= CENTER_RESET;
         cfg_ff.scale  <= SCALE_RESET;
         cfg_ff.kp     <= '0;
         cfg_ff.kd     <= '0;
         cfg_ff.base   <= '0;
         cfg_ff.limit  <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CENTER: csr_prdata = CSR_DATA_BITS'(cfg_ff.center);
         REG_SCALE:  csr_prdata = CSR_DATA_BITS'(cfg_ff.scale);
         REG_KP:     csr_prdata = CSR_DATA_BITS'(cfg_ff.kp);
         REG_KD:     csr_prdata = CSR_DATA_BITS'(cfg_ff.kd);
         REG_BASE:   csr_prdata = CSR_DATA_BITS'(cfg_ff.base);
         REG_LIMIT:  csr_prdata = CSR_DATA_BITS'(cfg_ff.limit);
         default:    csr_prdata = '0;
      endcase
   end

endmodule

>>> rtl/pdlf_datapath.sv
// ----------------------------------------------------------------------------
// PD line follower datapath
// Error, shared-step multiply-accumulate, restoring divider and drive clamp.
// ----------------------------------------------------------------------------
module pdlf_datapath #(
   parameter int POSITION_BITS = 13
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pdlf_pkg::cmd_type               cmd,
   output pdlf_pkg::sts_type               sts,
   input  pdlf_pkg::cfg_type               cfg,
   input  logic [POSITION_BITS-1:0]        position,
   output logic [pdlf_pkg::SPEED_BITS-1:0] left_drive,
   output logic [pdlf_pkg::SPEED_BITS-1:0] right_drive
);
   import pdlf_pkg::*;

   localparam int EW = ((POSITION_BITS > CENTER_BITS) ? POSITION_BITS : CENTER_BITS) + 1;
   localparam int DW = EW + 1;
   localparam int PW = EW + GAIN_BITS + 1;
   localparam int NW = EW + GAIN_BITS + 2;
   localparam int MW = NW - 1;
   localparam int SW = NW + 1;
   localparam int CW = $clog2(MW);

   logic [POSITION_BITS-1:0] pos_ff;
   logic signed [EW-1:0]     err_ff, last_ff;
   logic signed [EW-1:0]     err_in;
   logic signed [DW-1:0]     derr_ff;
   logic signed [PW-1:0]     prod_p;
   logic signed [NW-1:0]     prod_d;
   logic signed [NW-1:0]     num_ff;
   logic [NW-1:0]            num_abs;
   logic                     neg_ff;
   logic [MW-1:0]            quo_ff;
   logic [SCALE_BITS-1:0]    rem_ff;
   logic [SCALE_BITS-1:0]    div_ff;
   logic [SCALE_BITS:0]      rem_shift;
   logic [SCALE_BITS:0]      rem_diff;
   logic                     q_bit;
   logic [CW-1:0]            cnt_ff;
   logic signed [NW-1:0]     adj_ff;
   logic signed [SW-1:0]     base_ext, adj_ext, lim_ext;
   logic signed [SW-1:0]     left_sum, right_sum;
   logic [SPEED_BITS-1:0]    left_ff, right_ff;
   logic [SPEED_BITS-1:0]    left_in, right_in;

   assign err_in = $signed({{(EW-POSITION_BITS){1'b0}}, pos_ff})
                 - $signed({{(EW-CENTER_BITS){1'b0}}, cfg.center});

   assign prod_p = $signed({1'b0, cfg.kp}) * err_ff;
   assign prod_d = $signed({1'b0, cfg.kd}) * derr_ff;

   assign num_abs   = num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
   assign rem_shift = {rem_ff, quo_ff[MW-1]};
   assign rem_diff  = rem_shift - {1'b0, div_ff};
   assign q_bit     = !rem_diff[SCALE_BITS];

   assign sts.div_last = (cnt_ff == CW'(MW - 1));

   assign base_ext  = SW'($signed(cfg.base));
   assign adj_ext   = SW'(adj_ff);
   assign lim_ext   = $signed({{(SW-LIMIT_BITS){1'b0}}, cfg.limit});
   assign left_sum  = base_ext + adj_ext;
   assign right_sum = base_ext - adj_ext;

   always_comb begin
      if (left_sum > lim_ext) begin
         left_in = SPEED_BITS'(lim_ext);
      end else if (left_sum < -lim_ext) begin
         left_in = SPEED_BITS'(-lim_ext);
      end else begin
         left_in = SPEED_BITS'(left_sum);
      end
      if (right_sum > lim_ext) begin
         right_in = SPEED_BITS'(lim_ext);
      end else if (right_sum < -lim_ext) begin
         right_in = SPEED_BITS'(-lim_ext);
      end else begin
         right_in = SPEED_BITS'(right_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else if (cmd.diff) begin
         last_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_ff <= position;
      end
      if (cmd.diff) begin
         err_ff  <= err_in;
         derr_ff <= DW'(err_in) - DW'(last_ff);
      end
      if (cmd.mul_p) begin
         num_ff <= NW'(prod_p);
      end
      if (cmd.mul_d) begin
         num_ff <= num_ff + prod_d;
      end
      if (cmd.setup) begin
         neg_ff <= num_ff[NW-1];
         quo_ff <= num_abs[MW-1:0];
         rem_ff <= '0;
         div_ff <= (cfg.scale == '0) ? SCALE_BITS'(1) : cfg.scale;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= q_bit ? rem_diff[SCALE_BITS-1:0] : rem_shift[SCALE_BITS-1:0];
         quo_ff <= {quo_ff[MW-2:0], q_bit};
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (cmd.fix) begin
         adj_ff <= neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      end
      if (cmd.load_out) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign left_drive  = left_ff;
   assign right_drive = right_ff;

endmodule

>>> rtl/pdlf_ctrl.sv
// ----------------------------------------------------------------------------
// PD line follower controller
// Sequences one item through the datapath and owns the result handshake.
// ----------------------------------------------------------------------------
module pdlf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output pdlf_pkg::cmd_type cmd,
   input  pdlf_pkg::sts_type sts
);
   import pdlf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MULP,
      ST_MULD,
      ST_SETUP,
      ST_DIV,
      ST_FIX,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free  = !out_valid_ff || out_ready;
   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = out_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !out_ready;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MULP;
         end
         ST_MULP: begin
            cmd.mul_p = 1'b1;
            state_in  = ST_MULD;
         end
         ST_MULD: begin
            cmd.mul_d = 1'b1;
            state_in  = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> rtl/pd_line_follow_drive_core.sv
// ----------------------------------------------------------------------------
// PD line follower drive core
// Turns line-sensor positions into saturated left and right wheel speeds.
// ----------------------------------------------------------------------------
// One sensor position is taken at a time: a new position is accepted only
// once the previous one has gone through capture, error, both multiplies,
// divider setup, division, sign fix and output load. The restoring divider
// produces one quotient bit per cycle. A finished result sits in an output
// register, so a new position is accepted while the previous result waits.
// The drives come out as two's complement speeds packed into rsp_tdata.
module pd_line_follow_drive_core #(
   parameter int POSITION_BITS = 13
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [POSITION_BITS-1:0] sensed_position, remaining bits ignored
   input  logic [((POSITION_BITS+7)/8)*8-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [9:0] left_drive, [19:10] right_drive, [23:20] zero
   output logic [23:0]                         rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pdlf_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [pdlf_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [pdlf_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import pdlf_pkg::*;

   cfg_type               cfg;
   cmd_type               cmd;
   sts_type               sts;
   logic [SPEED_BITS-1:0] left_drive, right_drive;

   pdlf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pdlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .cmd       (cmd),
      .sts       (sts)
   );

   pdlf_datapath #(
      .POSITION_BITS (POSITION_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .cfg         (cfg),
      .position    (req_tdata[POSITION_BITS-1:0]),
      .left_drive  (left_drive),
      .right_drive (right_drive)
   );

   assign rsp_tdata = {4'b0000, right_drive, left_drive};

endmodule

>>> rtl/pdlf_checker.sv
// ----------------------------------------------------------------------------
// PD line follower port checker
// Watches the core's ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module pdlf_checker #(
   parameter int POSITION_BITS = 13
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [((POSITION_BITS+7)/8)*8-1:0]  req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [23:0]                         rsp_tdata,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [pdlf_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input logic [pdlf_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input logic [pdlf_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   input logic                                csr_pready
);

   // A held result beat keeps its payload until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("core not idle after reset");

   // An accepted position keeps the core busy for the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !$rose(rsp_tvalid))
      else $error("core accepted or finished too early");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:20] == 4'b0000)
      else $error("result padding bits not zero");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("register port not ready");

endmodule

bind pd_line_follow_drive_core pdlf_checker #(
   .POSITION_BITS (POSITION_BITS)
) u_pdlf_checker (.*);

>>> tb/pd_drive_checker.sv
// ----------------------------------------------------------------------------
// PD drive checker
// Watches the register port and both streams of the line follower drive core.
// It keeps its own copy of the registers and of the previous heading error,
// predicts the left and right drives for every accepted sensor beat, and
// compares each drive beat with the oldest prediction. Register reads are
// compared with the copy as well.
// ----------------------------------------------------------------------------
module pd_drive_checker #(
   parameter int POSITION_BITS = 13,
   parameter int DATA_BITS     = ((POSITION_BITS+7)/8)*8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [DATA_BITS-1:0]                req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [23:0]                         rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pdlf_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [pdlf_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input  logic [pdlf_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   input  logic                                csr_pready,
   output int                                  failures,
   output int                                  outstanding,
   output int                                  beats_checked
);

   import pdlf_pkg::*;

   typedef struct packed {
      logic [SPEED_BITS-1:0] right;
      logic [SPEED_BITS-1:0] left;
   } drive_pair_type;

   logic [CENTER_BITS-1:0] center_pos;
   logic [SCALE_BITS-1:0]  error_scale;
   logic [GAIN_BITS-1:0]   kp_value;
   logic [GAIN_BITS-1:0]   kd_value;
   logic [SPEED_BITS-1:0]  base_bits;
   logic [LIMIT_BITS-1:0]  speed_cap;
   longint                 last_heading;
   drive_pair_type         drive_queue[$];
   int                     fault_total = 0;
   int                     beat_total = 0;

   assign failures      = fault_total;
   assign beats_checked = beat_total;

   task automatic report_mismatch(input string what);
      fault_total++;
      if (fault_total <= 40) $display("mismatch at %0t: %s", $time, what);
   endtask

   function automatic longint clamp_speed(input longint speed, input longint cap);
      if (speed > cap) return cap;
      if (speed < -cap) return -cap;
      return speed;
   endfunction

   // The weighted error is held at full precision, so a drive can only
   // saturate and never wrap.
   function automatic drive_pair_type compute_drives(input logic [DATA_BITS-1:0] word);
      longint         position;
      longint         heading;
      longint         divisor;
      longint         weighted;
      longint         adjust;
      longint         left;
      longint         right;
      drive_pair_type pair;
      position = longint'(word) & ((longint'(1) << POSITION_BITS) - 1);
      heading  = position - longint'(center_pos);
      divisor  = (error_scale == '0) ? 1 : longint'(error_scale);
      weighted = longint'(kp_value) * heading
                 + longint'(kd_value) * (heading - last_heading);
      adjust   = weighted / divisor;
      left     = clamp_speed(longint'($signed(base_bits)) + adjust, longint'(speed_cap));
      right    = clamp_speed(longint'($signed(base_bits)) - adjust, longint'(speed_cap));
      last_heading = heading;
      pair.left    = left[SPEED_BITS-1:0];
      pair.right   = right[SPEED_BITS-1:0];
      return pair;
   endfunction

   always @(posedge clock) begin
      drive_pair_type want;
      logic [31:0]    reg_mask;
      logic [31:0]    reg_value;
      if (reset) begin
         center_pos   = CENTER_RESET;
         error_scale  = SCALE_RESET;
         kp_value     = '0;
         kd_value     = '0;
         base_bits    = '0;
         speed_cap    = LIMIT_RESET;
         last_heading = 0;
         drive_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[4:2])
                  REG_CENTER: center_pos  = csr_pwdata[CENTER_BITS-1:0];
                  REG_SCALE:  error_scale = csr_pwdata[SCALE_BITS-1:0];
                  REG_KP:     kp_value    = csr_pwdata[GAIN_BITS-1:0];
                  REG_KD:     kd_value    = csr_pwdata[GAIN_BITS-1:0];
                  REG_BASE:   base_bits   = csr_pwdata[SPEED_BITS-1:0];
                  REG_LIMIT:  speed_cap   = csr_pwdata[LIMIT_BITS-1:0];
                  default: ;
               endcase
            end else begin
               reg_mask  = '0;
               reg_value = '0;
               case (csr_paddr[4:2])
                  REG_CENTER: begin
                     reg_mask  = (32'd1 << CENTER_BITS) - 1;
                     reg_value = 32'(center_pos);
                  end
                  REG_SCALE: begin
                     reg_mask  = (32'd1 << SCALE_BITS) - 1;
                     reg_value = 32'(error_scale);
                  end
                  REG_KP: begin
                     reg_mask  = (32'd1 << GAIN_BITS) - 1;
                     reg_value = 32'(kp_value);
                  end
                  REG_KD: begin
                     reg_mask  = (32'd1 << GAIN_BITS) - 1;
                     reg_value = 32'(kd_value);
                  end
                  REG_BASE: begin
                     reg_mask  = (32'd1 << SPEED_BITS) - 1;
                     reg_value = 32'(base_bits);
                  end
                  REG_LIMIT: begin
                     reg_mask  = (32'd1 << LIMIT_BITS) - 1;
                     reg_value = 32'(speed_cap);
                  end
                  default: ;
               endcase
               if ((csr_prdata & reg_mask) !== reg_value)
                  report_mismatch($sformatf("register at %0d read %h expected %h",
                     csr_paddr, csr_prdata & reg_mask, reg_value));
            end
         end
         if (req_tvalid && req_tready)
            drive_queue.push_back(compute_drives(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (drive_queue.size() == 0) begin
               report_mismatch($sformatf("drive beat %h with no position waiting", rsp_tdata));
            end else begin
               want = drive_queue.pop_front();
               if (rsp_tdata[9:0] !== want.left)
                  report_mismatch($sformatf("left drive %0d expected %0d",
                     $signed(rsp_tdata[9:0]), $signed(want.left)));
               if (rsp_tdata[19:10] !== want.right)
                  report_mismatch($sformatf("right drive %0d expected %0d",
                     $signed(rsp_tdata[19:10]), $signed(want.right)));
               beat_total++;
            end
         end
      end
      outstanding <= drive_queue.size();
   end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// PD line follower drive testbench
// Drives sensor positions and register settings into the drive core while a
// checker predicts and compares every drive beat. A short directed part hits
// the register and position extremes; random settings then run trajectories
// around the line center, with random stalls on both streams in most phases.
// ----------------------------------------------------------------------------
module tb;

   import pdlf_pkg::*;

   localparam int POSITION_BITS  = 13;
   localparam int DATA_BITS      = ((POSITION_BITS+7)/8)*8;
   localparam int WATCHDOG_LIMIT = 4000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [DATA_BITS-1:0]      req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [23:0]               rsp_tdata;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   int   failures;
   int   outstanding;
   int   beats_checked;
   logic calm = 1'b0;
   int   track_center = 2500;
   int   track_scale = 2500;
   int   cur_position = 2500;
   int   positions_sent = 0;
   int   settings_applied = 0;
   int   idle_cycles = 0;

   always #5 clock = ~clock;

   pd_line_follow_drive_core #(.POSITION_BITS(POSITION_BITS)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   pd_drive_checker #(.POSITION_BITS(POSITION_BITS)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .failures(failures), .outstanding(outstanding), .beats_checked(beats_checked)
   );

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= calm || ($urandom_range(0, 99) >= 25);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   task automatic csr_access(input logic [2:0] index, input logic write,
                             input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_registers();
      for (int r = REG_CENTER; r <= REG_LIMIT; r++) csr_access(3'(r), 1'b0, '0);
   endtask

   task automatic apply_setting(input int center, input int scale, input int kp,
                                input int kd, input int base, input int limit);
      csr_access(REG_CENTER, 1'b1, 32'(center));
      csr_access(REG_SCALE,  1'b1, 32'(scale));
      csr_access(REG_KP,     1'b1, 32'(kp));
      csr_access(REG_KD,     1'b1, 32'(kd));
      csr_access(REG_BASE,   1'b1, 32'(base));
      csr_access(REG_LIMIT,  1'b1, 32'(limit));
      read_registers();
      track_center = center;
      track_scale  = scale;
      settings_applied++;
   endtask

   task automatic send_position(input logic [DATA_BITS-1:0] word);
      while (!calm && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      cur_position = int'(word[POSITION_BITS-1:0]);
      positions_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_setting();
      int kp;
      int kd;
      int limit;
      int base;
      if ($urandom_range(0, 1) == 1) begin
         track_center = $urandom_range(1500, 6500);
         track_scale  = $urandom_range(800, 4000);
         kp    = $urandom_range(0, 500);
         kd    = $urandom_range(0, 1500);
         limit = $urandom_range(150, 400);
      end else begin
         track_center = $urandom_range(0, 8191);
         track_scale  = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8191);
         kp    = $urandom_range(0, 4095);
         kd    = $urandom_range(0, 4095);
         limit = $urandom_range(0, 511);
      end
      base = int'($urandom_range(0, 800)) - 400;
      apply_setting(track_center, track_scale, kp, kd, base, limit);
   endtask

   // Mostly positions near the line, some slow drift, some arbitrary jumps.
   function automatic logic [DATA_BITS-1:0] pick_position();
      int         span;
      int         pos;
      int         mode;
      logic [2:0] spare;
      span  = (track_scale < 16) ? 16 : track_scale;
      mode  = $urandom_range(0, 9);
      spare = 3'($urandom_range(0, 7));
      if (mode < 6) pos = track_center + int'($urandom_range(0, 2 * span)) - span;
      else if (mode < 8) pos = cur_position + int'($urandom_range(0, 400)) - 200;
      else pos = $urandom_range(0, 8191);
      if (pos < 0) pos = 0;
      if (pos > 8191) pos = 8191;
      return {spare, 13'(pos)};
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      read_registers();
      send_position(16'h0000);
      send_position(16'hFFFF);
      send_position(16'd2500);
      settle();

      apply_setting(0, 0, 4095, 4095, 400, 511);
      send_position(16'hFFFF);
      send_position(16'hE000);
      send_position(16'h1FFF);
      send_position(16'h2000);
      settle();

      apply_setting(8191, 1, 4095, 0, -400, 0);
      send_position(16'h0000);
      send_position(16'h1FFF);
      send_position(16'h4000);
      settle();

      apply_setting(4096, 8191, 1, 4095, -1, 400);
      send_position(16'd4096);
      send_position(16'd4095);
      send_position(16'd4097);
      send_position(16'd0);
      send_position(16'd8191);
      settle();

      apply_setting(3500, 3500, 300, 900, 250, 400);
      send_position(16'd3500);
      send_position(16'd3700);
      send_position(16'd3300);
      send_position(16'd1000);
      send_position(16'd6000);
      settle();

      for (int phase = 0; phase < 10; phase++) begin
         calm <= (phase == 4 || phase == 5);
         random_setting();
         repeat (110) send_position(pick_position());
         settle();
      end

      repeat (40) @(posedge clock);
      $display("Run covered %0d sensor positions under %0d register settings.",
               positions_sent, settings_applied);
      $display("%0d drive beats compared; gains, error scales and limits hit both ends.",
               beats_checked);
      if (failures == 0 && outstanding == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
